// ----- design/assert_macros.svh -----
// Assertion macros used by the top level of the expert slot cache.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define ESL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ESL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- design/esl_pkg.sv -----
// Types, codes and default sizes of the expert slot cache.
package esl_pkg;

    localparam int ESL_LAYERS  = 64;
    localparam int ESL_SLOTS   = 16;
    localparam int ESL_EXPERTS = 256;

    localparam int LAYER_W    = 6;
    localparam int EXPERT_W   = 8;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 4;
    localparam int OFFSET_W   = 48;
    localparam int COUNT_W    = 32;
    localparam int BYTES_W    = 64;
    localparam int STAMP_W    = 32;
    localparam int KEY_W      = STAMP_W + 1;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPERT_COUNT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPERT_BYTES = 8'd3;

    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd0;
    localparam logic [STATUS_W-1:0] ST_HIT    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS   = 2'd2;

    typedef struct packed {
        logic [LAYER_W-1:0]  layer;
        logic [EXPERT_W-1:0] expert;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [OFFSET_W-1:0]   fetch_offset;
        logic [COUNT_W-1:0]    hit_total;
        logic [COUNT_W-1:0]    pagein_total;
        logic [BYTES_W-1:0]    bytes_total;
    } t_res;

endpackage

// ----- design/esl_row_mem.sv -----
// Slot row memory: one row per layer, registered read, row valid bits, write forwarding.
module esl_row_mem
    import esl_pkg::*;
#(
    parameter int DEPTH  = ESL_LAYERS,
    parameter int ADDR_W = $clog2(ESL_LAYERS),
    parameter int ROW_W  = ESL_SLOTS * ($clog2(ESL_EXPERTS) + STAMP_W + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [ROW_W-1:0]  i_wdata,
    output logic [ROW_W-1:0]  o_rdata
);

    logic [ROW_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_row_ok;
    logic [ROW_W-1:0] r_rdata;
    logic             r_rd_ok;
    logic             fwd;

    // A read of the row written at the same edge returns the new row.
    assign fwd = i_we && (i_waddr == i_raddr);

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= fwd ? i_wdata : r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok <= '0;
            r_rd_ok  <= 1'b0;
        end else begin
            if (i_we) begin
                r_row_ok[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_ok <= r_row_ok[i_raddr] | fwd;
            end
        end
    end

    // A row never written reads as all slots empty with stamp zero.
    assign o_rdata = r_rd_ok ? r_rdata : '0;

endmodule

// ----- design/esl_lookup.sv -----
// Row lookup: tag compare, hit encoder and the first levels of the oldest-slot tree.
module esl_lookup
    import esl_pkg::*;
#(
    parameter int SLOTS = ESL_SLOTS,
    parameter int TAG_W = $clog2(ESL_EXPERTS)
) (
    input  logic                                      i_clk,
    input  logic                                      i_en,
    input  logic [SLOTS*(TAG_W+STAMP_W+1)-1:0]        i_row,
    input  logic [EXPERT_W-1:0]                       i_expert,
    input  logic [$clog2(SLOTS+1)-1:0]                i_act,
    output logic                                      o_hit,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] o_hit_idx,
    output logic [KEY_W-1:0] o_cand_key [(1 << $clog2(SLOTS)) >> ($clog2(SLOTS) / 2)],
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0]
                 o_cand_idx [(1 << $clog2(SLOTS)) >> ($clog2(SLOTS) / 2)],
    output logic [SLOTS*(TAG_W+STAMP_W+1)-1:0]        o_row
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ENT_W  = TAG_W + STAMP_W + 1;
    localparam int LEVELS = $clog2(SLOTS);
    localparam int P      = 1 << LEVELS;
    localparam int MID    = LEVELS / 2;
    localparam int CAND   = P >> MID;

    logic [ENT_W-1:0]  ent;
    logic              hit_c;
    logic [SLOT_W-1:0] hit_idx_c;
    logic [KEY_W-1:0]  key [P];
    logic [SLOT_W-1:0] idx [P];

    always_comb begin
        hit_c     = 1'b0;
        hit_idx_c = '0;
        ent       = '0;
        // Scan downward so the lowest matching slot wins.
        for (int s = SLOTS - 1; s >= 0; s--) begin
            ent = i_row[s*ENT_W +: ENT_W];
            if (ent[ENT_W-1] && (ent[STAMP_W +: TAG_W] == TAG_W'(i_expert))
                    && (s < int'(i_act))) begin
                hit_c     = 1'b1;
                hit_idx_c = SLOT_W'(s);
            end
        end
    end

    // Key is {inactive, stamp}; the right node wins only when strictly smaller,
    // so ties go to the lower slot.
    always_comb begin
        for (int s = 0; s < SLOTS; s++) begin
            key[s] = {(s >= int'(i_act)), i_row[s*ENT_W +: STAMP_W]};
            idx[s] = SLOT_W'(s);
        end
        for (int s = SLOTS; s < P; s++) begin
            key[s] = '1;
            idx[s] = SLOT_W'(s);
        end
        for (int lv = 0; lv < MID; lv++) begin
            for (int j = 0; j < (P >> (lv + 1)); j++) begin
                if (key[2*j+1] < key[2*j]) begin
                    key[j] = key[2*j+1];
                    idx[j] = idx[2*j+1];
                end else begin
                    key[j] = key[2*j];
                    idx[j] = idx[2*j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_hit     <= hit_c;
            o_hit_idx <= hit_idx_c;
            o_row     <= i_row;
            for (int c = 0; c < CAND; c++) begin
                o_cand_key[c] <= key[c];
                o_cand_idx[c] <= idx[c];
            end
        end
    end

endmodule

// ----- design/expert_slot_lru_cache.sv -----
// Top level of the expert slot cache: control, victim choice, write back and counters.
//
//  Channel  Direction  Handshake                  Payload
//  in       input      i_in_valid / o_in_ready    i_in  (t_req: layer, expert)
//  out      output     o_out_valid / i_out_ready  o_out (t_res: status .. bytes_total)
//  cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A request runs in steps: the layer's row is read from the row memory, then the
// tag compare and oldest-slot tree run, then the row is written back while the next
// request's row read starts; a request is accepted only while idle or as the last
// one is written back. The result is registered; a full output register holds
// the request in its last stage. Reset is synchronous and clears the row valid
// bits at once, so no clearing pass is needed.
`include "assert_macros.svh"

module expert_slot_lru_cache
    import esl_pkg::*;
#(
    parameter int LAYERS  = ESL_LAYERS,
    parameter int SLOTS   = ESL_SLOTS,
    parameter int EXPERTS = ESL_EXPERTS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_req                  i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_res                  o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LAYER_AW = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NS_W     = $clog2(SLOTS + 1);
    localparam int TAG_W    = $clog2(EXPERTS);
    localparam int ENT_W    = TAG_W + STAMP_W + 1;
    localparam int ROW_W    = SLOTS * ENT_W;
    localparam int LEVELS   = $clog2(SLOTS);
    localparam int MID      = LEVELS / 2;
    localparam int CAND     = (1 << LEVELS) >> MID;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_PICK = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    logic [6:0]  r_layer_cnt;
    logic [8:0]  r_expert_cnt;
    logic [4:0]  r_slots_cfg;
    logic [39:0] r_bytes_cfg;

    logic [LAYER_AW-1:0] r_addr;
    logic [EXPERT_W-1:0] r_exp;
    logic                r_ok;
    logic [OFFSET_W-1:0] r_offset;

    logic [STAMP_W-1:0] r_clock;
    logic [COUNT_W-1:0] r_hits;
    logic [COUNT_W-1:0] r_pageins;
    logic [BYTES_W-1:0] r_bytes;
    logic [STAMP_W-1:0] n_clock;
    logic [COUNT_W-1:0] n_hits;
    logic [COUNT_W-1:0] n_pageins;
    logic [BYTES_W-1:0] n_bytes;

    logic r_out_valid;
    t_res r_out;
    t_res n_out;

    logic                in_acc;
    logic                in_ok;
    logic                out_free;
    logic                advance;
    logic                mem_we;
    logic [ROW_W-1:0]    mem_rdata;
    logic [NS_W-1:0]     act_slots;
    logic [8:0]          slots_ext;
    logic [OFFSET_W-1:0] prod;
    logic [BYTES_W:0]    byte_sum;

    logic              look_hit;
    logic [SLOT_W-1:0] look_hit_idx;
    logic [KEY_W-1:0]  look_key [CAND];
    logic [SLOT_W-1:0] look_idx [CAND];
    logic [ROW_W-1:0]  look_row;

    logic [KEY_W-1:0]  key2 [CAND];
    logic [SLOT_W-1:0] idx2 [CAND];
    logic [SLOT_W-1:0] victim;
    logic [SLOT_W-1:0] slot_sel;
    logic [ROW_W-1:0]  n_wrow;

    // Handshakes and request check.
    assign out_free    = !r_out_valid || i_out_ready;
    assign advance     = (r_state == ST_PICK) && out_free;
    assign o_in_ready  = (r_state == ST_IDLE) || advance;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign in_ok = (7'(i_in.layer) < r_layer_cnt) && (32'(i_in.layer) < LAYERS)
                && (9'(i_in.expert) < r_expert_cnt) && (32'(i_in.expert) < EXPERTS);

    always_comb begin
        slots_ext = 9'(r_slots_cfg);
        if (slots_ext == 9'd0) begin
            act_slots = NS_W'(1);
        end else if (slots_ext > 9'(SLOTS)) begin
            act_slots = NS_W'(SLOTS);
        end else begin
            act_slots = NS_W'(slots_ext);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) n_state = ST_LOOK;
            end
            ST_LOOK: begin
                n_state = ST_PICK;
            end
            ST_PICK: begin
                if (advance) n_state = in_acc ? ST_LOOK : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer_cnt  <= 7'd1;
            r_expert_cnt <= 9'd1;
            r_slots_cfg  <= 5'd1;
            r_bytes_cfg  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LAYER_COUNT:  r_layer_cnt  <= i_cfg_data[6:0];
                CFG_EXPERT_COUNT: r_expert_cnt <= i_cfg_data[8:0];
                CFG_SLOTS_IN_USE: r_slots_cfg  <= i_cfg_data[4:0];
                CFG_EXPERT_BYTES: r_bytes_cfg  <= i_cfg_data[39:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok <= 1'b0;
        end else if (in_acc) begin
            r_ok <= in_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_addr <= LAYER_AW'(i_in.layer);
            r_exp  <= i_in.expert;
        end
    end

    // Page-in offset is formed while the row is searched.
    assign prod = r_exp * r_bytes_cfg;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOOK) begin
            r_offset <= prod;
        end
    end

    esl_row_mem #(
        .DEPTH  (LAYERS),
        .ADDR_W (LAYER_AW),
        .ROW_W  (ROW_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (in_acc && in_ok),
        .i_raddr (LAYER_AW'(i_in.layer)),
        .i_we    (mem_we),
        .i_waddr (r_addr),
        .i_wdata (n_wrow),
        .o_rdata (mem_rdata)
    );

    esl_lookup #(
        .SLOTS (SLOTS),
        .TAG_W (TAG_W)
    ) u_look (
        .i_clk      (i_clk),
        .i_en       (r_state == ST_LOOK),
        .i_row      (mem_rdata),
        .i_expert   (r_exp),
        .i_act      (act_slots),
        .o_hit      (look_hit),
        .o_hit_idx  (look_hit_idx),
        .o_cand_key (look_key),
        .o_cand_idx (look_idx),
        .o_row      (look_row)
    );

    // Remaining levels of the oldest-slot tree.
    always_comb begin
        for (int c = 0; c < CAND; c++) begin
            key2[c] = look_key[c];
            idx2[c] = look_idx[c];
        end
        for (int lv = 0; lv < LEVELS - MID; lv++) begin
            for (int j = 0; j < (CAND >> (lv + 1)); j++) begin
                if (key2[2*j+1] < key2[2*j]) begin
                    key2[j] = key2[2*j+1];
                    idx2[j] = idx2[2*j+1];
                end else begin
                    key2[j] = key2[2*j];
                    idx2[j] = idx2[2*j];
                end
            end
        end
        victim = idx2[0];
    end

    assign slot_sel = look_hit ? look_hit_idx : victim;
    assign mem_we   = advance && r_ok;
    assign byte_sum = {1'b0, r_bytes} + (BYTES_W + 1)'(r_bytes_cfg);

    always_comb begin
        n_clock   = r_clock;
        n_hits    = r_hits;
        n_pageins = r_pageins;
        n_bytes   = r_bytes;
        if (r_ok) begin
            n_clock = (r_clock == '1) ? r_clock : r_clock + 1'b1;
            if (look_hit) begin
                n_hits = (r_hits == '1) ? r_hits : r_hits + 1'b1;
            end else begin
                n_pageins = (r_pageins == '1) ? r_pageins : r_pageins + 1'b1;
                n_bytes   = byte_sum[BYTES_W] ? '1 : byte_sum[BYTES_W-1:0];
            end
        end
    end

    always_comb begin
        n_wrow = look_row;
        n_wrow[slot_sel*ENT_W +: ENT_W] = {1'b1, TAG_W'(r_exp), n_clock};
    end

    always_comb begin
        n_out.status       = !r_ok ? ST_REJECT : (look_hit ? ST_HIT : ST_MISS);
        n_out.slot         = r_ok ? SLOT_OUT_W'(slot_sel) : '0;
        n_out.fetch_offset = (r_ok && !look_hit) ? r_offset : '0;
        n_out.hit_total    = n_hits;
        n_out.pagein_total = n_pageins;
        n_out.bytes_total  = n_bytes;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock   <= '0;
            r_hits    <= '0;
            r_pageins <= '0;
            r_bytes   <= '0;
        end else if (advance) begin
            r_clock   <= n_clock;
            r_hits    <= n_hits;
            r_pageins <= n_pageins;
            r_bytes   <= n_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    `ESL_ASSERT(a_acc_to_look, in_acc |=> (r_state == ST_LOOK), "accepted request did not enter lookup")
    `ESL_ASSERT(a_we_in_pick, mem_we |-> ((r_state == ST_PICK) && out_free), "row written outside final stage")
    `ESL_ASSERT(a_out_from_pick, $rose(o_out_valid) |-> ($past(r_state) == ST_PICK), "result without final stage")
    `ESL_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (!o_out_valid && (r_state == ST_IDLE)), "reset left work pending")

endmodule
